// File: rtl/iqss_pkg.sv
`default_nettype none

package iqss_pkg;

  localparam int DEST_W      = 3;
  localparam int WAIT_W      = 8;
  localparam int NUM_OUTPUTS = 2 ** DEST_W;
  localparam int FIELD_PORTS = 8;
  localparam int ACTIVE_W    = 4;
  localparam int PADDR_W     = 3;

  localparam logic [WAIT_W-1:0]   WAIT_LIMIT         = 8'd253;
  localparam logic [WAIT_W-1:0]   DELAY_OFFSET       = 8'd2;
  localparam logic [ACTIVE_W-1:0] ACTIVE_PORTS_RESET = 4'd8;

  // Register index as decoded from paddr[2].
  localparam logic [0:0] REG_ACTIVE_PORTS = 1'b0;

  typedef logic [DEST_W-1:0] dest_t;
  typedef logic [WAIT_W-1:0] wait_t;

  typedef struct packed {
    logic  valid;
    dest_t dest;
  } lane_req_t;

  typedef struct packed {
    logic arrive;
    logic arbitrate;
    logic load;
  } lane_ctl_t;

endpackage

`default_nettype wire

// File: rtl/iqss_ram.sv
`default_nettype none

module iqss_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/iqss_lane.sv
`default_nettype none

module iqss_lane #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire iqss_pkg::lane_ctl_t ctl,
  input  wire logic                arr_en,
  input  wire iqss_pkg::dest_t     arr_dest,
  input  wire logic                grant,
  output iqss_pkg::lane_req_t      req,
  output iqss_pkg::wait_t          head_wait,
  output logic                     drop
);

  import iqss_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = ((PTR_W > OCC_W) ? PTR_W : OCC_W) + 1;

  logic [OCC_W-1:0] occ;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] ptr_inc;
  logic [PTR_W-1:0] tail;
  logic [SUM_W-1:0] tail_sum;
  logic             reload;
  logic             full;
  logic             push;
  logic             served;
  dest_t            head_dest;
  dest_t            rdata;

  always_comb begin
    full     = (occ == OCC_W'(QUEUE_DEPTH));
    push     = ctl.arrive && arr_en && !full;
    drop     = ctl.arrive && arr_en && full;
    served   = ctl.arbitrate && (occ != '0) && grant;
    ptr_inc  = (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    // rd_ptr + occ stays below twice the depth, so one subtract wraps it.
    tail_sum = SUM_W'(rd_ptr) + SUM_W'(occ);
    if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
    end
    tail      = tail_sum[PTR_W-1:0];
    req.valid = (occ != '0);
    req.dest  = head_dest;
  end

  iqss_ram #(
    .WIDTH (DEST_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (push),
    .waddr (tail),
    .wdata (arr_dest),
    .raddr (ptr_inc),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      occ    <= '0;
      rd_ptr <= '0;
      reload <= 1'b0;
    end else begin
      if (push) begin
        occ <= occ + 1'b1;
      end
      if (served) begin
        occ    <= occ - 1'b1;
        rd_ptr <= ptr_inc;
        reload <= (occ > OCC_W'(1));
      end
      if (ctl.load) begin
        reload <= 1'b0;
      end
    end
  end

  // The head entry lives in registers; the store is read only to refill it.
  always_ff @(posedge clk) begin
    if (push && (occ == '0)) begin
      head_dest <= arr_dest;
      head_wait <= '0;
    end
    if (ctl.arbitrate && (occ != '0)) begin
      if (grant) begin
        head_wait <= '0;
      end else if (head_wait < WAIT_LIMIT) begin
        head_wait <= head_wait + 1'b1;
      end
    end
    if (ctl.load && reload) begin
      head_dest <= rdata;
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(QUEUE_DEPTH))
    else $error("queue occupancy above depth");

  a_grant_needs_head: assert property (@(posedge clk) disable iff (rst)
    (ctl.arbitrate && grant) |-> (occ != '0))
    else $error("grant to an empty queue");

  a_reload_after_serve: assert property (@(posedge clk) disable iff (rst)
    reload |-> $past(served))
    else $error("head refill without a departure");

endmodule

`default_nettype wire

// File: rtl/iqss_arbiter.sv
`default_nettype none

module iqss_arbiter #(
  parameter int NUM_PORTS = 8
) (
  input  wire iqss_pkg::lane_req_t [NUM_PORTS-1:0] req,
  output logic [NUM_PORTS-1:0]                     grant,
  output logic [iqss_pkg::NUM_OUTPUTS-1:0]         taken
);

  import iqss_pkg::*;

  logic blocked;

  // Each output takes the lowest-index input whose head asks for it.
  always_comb begin
    blocked = 1'b0;
    grant   = '0;
    taken   = '0;
    for (int i = 0; i < NUM_PORTS; i++) begin
      blocked = 1'b0;
      for (int k = 0; k < NUM_PORTS; k++) begin
        if ((k < i) && req[k].valid && (req[k].dest == req[i].dest)) begin
          blocked = 1'b1;
        end
      end
      grant[i] = req[i].valid && !blocked;
      if (grant[i]) begin
        taken[req[i].dest] = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/input_queued_switch_scheduler.sv
// Input-queued crossbar scheduler. Each word on the slave stream is one time
// slot: s_tdata carries the arrival mask and a 3-bit destination per input.
// Arrivals are queued per input, then every output grants the lowest-index
// input whose head packet is addressed to it. One result word per slot leaves
// on the master stream with the served inputs, their delays (wait + 2), the
// inputs whose arrivals found a full queue, and the outputs that carried data.
// An item passes through these steps in order: accept, enqueue, arbitrate, head
// refill from the per-input store (one registered read), and result load. A new
// word is accepted only after the previous result word has been loaded.
// If the receiver stalls, the finished word waits in the output register and
// the block holds in its final step until the word is taken.
// The APB port holds active_ports at address 0; write it only while no slot
// is in flight. Reset empties all queues, sets active_ports to 8 and
// drops any pending result word.
`default_nettype none

module input_queued_switch_scheduler #(
  parameter int NUM_PORTS   = 8,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // arrival_mask [7:0], arrival_dests [31:8]
  input  wire logic [31:0]                  s_tdata,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  // served_mask [7:0], served_delays [71:8], dropped_mask [79:72],
  // granted_outputs [87:80]
  output logic      [87:0]                  m_tdata,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [iqss_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready
);

  import iqss_pkg::*;

  localparam int CNT_W = $clog2(NUM_PORTS + 1);
  localparam int CMP_W = (CNT_W > ACTIVE_W) ? CNT_W : ACTIVE_W;
  localparam int SHOWN = (NUM_PORTS < FIELD_PORTS) ? NUM_PORTS : FIELD_PORTS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ARRIVE,
    S_ARB,
    S_LOAD,
    S_SEND
  } state_t;

  state_t                    state;
  logic [ACTIVE_W-1:0]       active_ports;
  logic [7:0]                in_mask;
  logic [23:0]               in_dests;
  logic [7:0]                res_served;
  logic [63:0]               res_delays;
  logic [7:0]                res_dropped;
  logic [NUM_OUTPUTS-1:0]    res_taken;

  logic [CMP_W-1:0]          ap_ext;
  logic [CMP_W-1:0]          eff_ports;
  lane_ctl_t                 ctl;
  lane_req_t [NUM_PORTS-1:0] req;
  logic [NUM_PORTS-1:0]      grant;
  logic [NUM_PORTS-1:0]      lane_drop;
  logic [NUM_PORTS-1:0]      arr_en;
  dest_t                     arr_dest [NUM_PORTS];
  wait_t                     lane_wait [NUM_PORTS];
  logic [NUM_OUTPUTS-1:0]    taken;
  logic [7:0]                drop_vec;
  logic [7:0]                served_vec;
  logic [63:0]               delay_vec;
  logic                      cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2:2] == REG_ACTIVE_PORTS) ? 32'(active_ports) : 32'd0;
  assign s_tready  = (state == S_IDLE);

  always_comb begin
    ap_ext        = CMP_W'(active_ports);
    eff_ports     = (ap_ext > CMP_W'(NUM_PORTS)) ? CMP_W'(NUM_PORTS) : ap_ext;
    ctl.arrive    = (state == S_ARRIVE);
    ctl.arbitrate = (state == S_ARB);
    ctl.load      = (state == S_LOAD);
  end

  for (genvar i = 0; i < NUM_PORTS; i++) begin : g_lane
    if (i < FIELD_PORTS) begin : g_fed
      assign arr_dest[i] = in_dests[3*i +: 3];
      assign arr_en[i]   = in_mask[i] && (CMP_W'(i) < eff_ports) &&
                           (CMP_W'(in_dests[3*i +: 3]) < eff_ports);
    end else begin : g_unfed
      assign arr_dest[i] = '0;
      assign arr_en[i]   = 1'b0;
    end

    iqss_lane #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .arr_en    (arr_en[i]),
      .arr_dest  (arr_dest[i]),
      .grant     (grant[i]),
      .req       (req[i]),
      .head_wait (lane_wait[i]),
      .drop      (lane_drop[i])
    );
  end

  iqss_arbiter #(
    .NUM_PORTS (NUM_PORTS)
  ) u_arbiter (
    .req   (req),
    .grant (grant),
    .taken (taken)
  );

  always_comb begin
    drop_vec   = '0;
    served_vec = '0;
    delay_vec  = '0;
    for (int i = 0; i < SHOWN; i++) begin
      drop_vec[i]   = lane_drop[i];
      served_vec[i] = grant[i];
      if (grant[i]) begin
        delay_vec[8*i +: 8] = lane_wait[i] + DELAY_OFFSET;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      m_tvalid     <= 1'b0;
      active_ports <= ACTIVE_PORTS_RESET;
    end else begin
      if (cfg_write && (paddr[2:2] == REG_ACTIVE_PORTS)) begin
        active_ports <= pwdata[ACTIVE_W-1:0];
      end
      // In the send step the output register is handled below.
      if (m_tvalid && m_tready && (state != S_SEND)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            in_mask  <= s_tdata[7:0];
            in_dests <= s_tdata[31:8];
            state    <= S_ARRIVE;
          end
        end
        S_ARRIVE: begin
          res_dropped <= drop_vec;
          state       <= S_ARB;
        end
        S_ARB: begin
          res_served <= served_vec;
          res_delays <= delay_vec;
          res_taken  <= taken;
          state      <= S_LOAD;
        end
        S_LOAD: begin
          state <= S_SEND;
        end
        S_SEND: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {res_taken, res_dropped, res_delays, res_served};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_grant_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($countones(m_tdata[7:0]) == $countones(m_tdata[87:80])))
    else $error("served inputs and granted outputs disagree");

  a_delay_iff_served: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[7:0] == 8'd0) == (m_tdata[71:8] == 64'd0)))
    else $error("delay bytes do not match served inputs");

  a_load_from_send: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_SEND))
    else $error("result word loaded outside the send step");

endmodule

`default_nettype wire
